[sv/ermk_pkg.sv]
// shared types, character codes and plan helpers for the entity reference marker
package ermk_pkg;

  localparam int MaxRefLenDef = 32;

  // character codes
  localparam logic [7:0] ChAmp  = 8'h26;
  localparam logic [7:0] ChHash = 8'h23;
  localparam logic [7:0] ChSemi = 8'h3B;
  localparam logic [7:0] ChLt   = 8'h3C;
  localparam logic [7:0] ChGt   = 8'h3E;
  localparam logic [7:0] ChXLo  = 8'h78;
  localparam logic [7:0] ChXUp  = 8'h58;

  // result kinds
  localparam logic [1:0] KindLit  = 2'd0;
  localparam logic [1:0] KindMark = 2'd1;
  localparam logic [1:0] KindEnd  = 2'd2;

  typedef enum logic [1:0] {PhIdle, PhAmp, PhHash, PhBody} phase_e;

  typedef enum logic [2:0] {ClsIdleAmp, ClsIdleLit, ClsPush, ClsClose, ClsBreak} cls_e;

  typedef enum logic [2:0] {SrcAmp, SrcChr, SrcLitIn, SrcLitHold, SrcMark, SrcEnd} src_e;

  typedef enum logic [2:0] {StIdle, StRamp, StRchr, StOne, StEnd} state_e;

  typedef struct packed {
    logic accept;
    logic emit;
    src_e src;
    logic run_last;
    logic idx_inc;
    logic rp_done;
  } dp_cmd_t;

  typedef struct packed {
    cls_e cls;
    logic byte_amp;
    logic in_tag;
    logic cnt_zero;
    logic idx_end;
    logic slot_free;
  } dp_sts_t;

  // work still owed for the current item, in emission order
  typedef struct packed {
    logic rp1;
    logic one;
    logic mark;
    logic rp2;
    logic fin;
  } plan_t;

  function automatic state_e first_stage(plan_t p);
    state_e s;
    if (p.rp1) begin
      s = StRamp;
    end else if (p.one) begin
      s = StOne;
    end else if (p.rp2) begin
      s = StRamp;
    end else if (p.fin) begin
      s = StEnd;
    end else begin
      s = StIdle;
    end
    return s;
  endfunction

  function automatic plan_t clear_rp(plan_t p);
    plan_t q;
    q = p;
    if (p.rp1) begin
      q.rp1 = 1'b0;
    end else begin
      q.rp2 = 1'b0;
    end
    return q;
  endfunction

  function automatic plan_t clear_one(plan_t p);
    plan_t q;
    q = p;
    q.one = 1'b0;
    return q;
  endfunction

endpackage

[sv/entity_reference_marker.sv]
// top level: streaming entity reference marker, controller plus datapath
// a transfer's own result shows in the cycle after the transfer; a replayed '&' is loaded from the replay state
// throughput: one byte per cycle while each byte yields at most one result and out_ready_i holds
// a broken reference holds the input while the '&', the buffered bytes (up to MaxRefLen - 1) and the breaking
//   byte are replayed (a breaking '&' starts a new reference instead); a final byte adds the end item
// reset: tag flag, scan phase, pending count and controller clear at once; buffer has no reset
module entity_reference_marker #(
  parameter int MaxRefLen = ermk_pkg::MaxRefLenDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input channel, one document byte per transfer
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  // output channel, one result per transfer
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] out_kind_o,
  output logic       run_last_o
);
  import ermk_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // controller decides, per transfer, the order of replay, literal or marker, and end item
  ermk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_last_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath holds the scan state, the pending bytes and the output register
  ermk_dp #(
    .MaxRefLen (MaxRefLen)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_byte_i   (in_byte_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o),
    .out_kind_o  (out_kind_o),
    .run_last_o  (run_last_o)
  );

endmodule

[sv/ermk_dp.sv]
// datapath: scan state, pending byte buffer, classification and output register
module ermk_dp #(
  parameter int MaxRefLen = ermk_pkg::MaxRefLenDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        in_byte_i,
  input  ermk_pkg::dp_cmd_t cmd_i,
  output ermk_pkg::dp_sts_t sts_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [7:0]        out_byte_o,
  output logic [1:0]        out_kind_o,
  output logic              run_last_o
);
  import ermk_pkg::*;

  localparam int Depth = (MaxRefLen - 1 > 2) ? MaxRefLen - 1 : 2;
  localparam int IdxW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);
  localparam logic [CntW-1:0] RoomLim = CntW'(MaxRefLen - 1);

  logic            tag_q, tag_d;
  phase_e          phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      byte_q;
  logic [7:0]      rdata_q;
  logic [7:0]      mem [Depth];

  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q, out_byte_d;
  logic [1:0]      out_kind_q, out_kind_d;
  logic            run_last_q, run_last_d;

  logic            alnum, room, slot_free, load;
  cls_e            cls;

  function automatic logic is_alnum(logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A);
  endfunction

  assign alnum     = is_alnum(in_byte_i);
  assign room      = cnt_q < RoomLim;
  assign slot_free = !out_valid_q || out_ready_i;
  assign load      = cmd_i.emit && slot_free;

  always_comb begin
    case (phase_q)
      PhIdle: begin
        cls = (in_byte_i == ChAmp) ? ClsIdleAmp : ClsIdleLit;
      end
      default: begin
        if ((phase_q == PhAmp && in_byte_i == ChHash) ||
            (phase_q == PhHash && (in_byte_i == ChXLo || in_byte_i == ChXUp)) ||
            (alnum && room)) begin
          cls = ClsPush;
        end else if (in_byte_i == ChSemi && cnt_q != '0) begin
          cls = ClsClose;
        end else begin
          cls = ClsBreak;
        end
      end
    endcase
  end

  always_comb begin
    sts_o.cls       = cls;
    sts_o.byte_amp  = in_byte_i == ChAmp;
    sts_o.in_tag    = tag_q;
    sts_o.cnt_zero  = cnt_q == '0;
    sts_o.idx_end   = (CntW'(idx_q) + CntW'(1)) == cnt_q;
    sts_o.slot_free = slot_free;
  end

  // scan state update
  always_comb begin
    tag_d   = tag_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    if (cmd_i.accept) begin
      case (cls)
        ClsIdleAmp: begin
          phase_d = PhAmp;
          cnt_d   = '0;
        end
        ClsIdleLit: begin
          if (in_byte_i == ChLt) begin
            tag_d = 1'b1;
          end else if (in_byte_i == ChGt) begin
            tag_d = 1'b0;
          end
        end
        ClsPush: begin
          cnt_d   = cnt_q + CntW'(1);
          phase_d = (phase_q == PhAmp && in_byte_i == ChHash) ? PhHash : PhBody;
        end
        ClsClose: begin
          cnt_d   = '0;
          phase_d = PhIdle;
        end
        ClsBreak: begin
          if (in_byte_i == ChLt) begin
            tag_d = 1'b1;
          end else if (in_byte_i == ChGt) begin
            tag_d = 1'b0;
          end
          phase_d = (in_byte_i == ChAmp) ? PhAmp : PhIdle;
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
    if (cmd_i.idx_inc) begin
      idx_d = idx_q + IdxW'(1);
    end
    if (cmd_i.rp_done) begin
      cnt_d = '0;
      idx_d = '0;
    end
    if (load && cmd_i.src == SrcEnd) begin
      tag_d   = 1'b0;
      phase_d = PhIdle;
      cnt_d   = '0;
      idx_d   = '0;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_kind_d  = out_kind_q;
    run_last_d  = run_last_q;
    if (load) begin
      out_valid_d = 1'b1;
      run_last_d  = cmd_i.run_last;
      case (cmd_i.src)
        SrcAmp: begin
          out_byte_d = ChAmp;
          out_kind_d = KindLit;
        end
        SrcChr: begin
          out_byte_d = rdata_q;
          out_kind_d = KindLit;
        end
        SrcLitIn: begin
          out_byte_d = in_byte_i;
          out_kind_d = KindLit;
        end
        SrcLitHold: begin
          out_byte_d = byte_q;
          out_kind_d = KindLit;
        end
        SrcMark: begin
          out_byte_d = '0;
          out_kind_d = KindMark;
        end
        default: begin
          out_byte_d = '0;
          out_kind_d = KindEnd;
        end
      endcase
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q       <= 1'b0;
      phase_q     <= PhIdle;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      tag_q       <= tag_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_kind_q <= out_kind_d;
    run_last_q <= run_last_d;
    if (cmd_i.accept) begin
      byte_q <= in_byte_i;
    end
  end

  // pending byte buffer, read data always tracks the replay index
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && cls == ClsPush) begin
      mem[cnt_q[IdxW-1:0]] <= in_byte_i;
    end
    rdata_q <= mem[idx_d];
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_kind_o  = out_kind_q;
  assign run_last_o  = run_last_q;

endmodule

[sv/ermk_ctrl.sv]
// controller: sequences replays, single results and the end item per transfer
module ermk_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  input  ermk_pkg::dp_sts_t sts_i,
  output ermk_pkg::dp_cmd_t cmd_o
);
  import ermk_pkg::*;

  state_e state_q, state_d;
  plan_t  plan_q, plan_d;
  plan_t  new_plan, new_rest, q_no_one, q_no_rp;
  state_e new_first;
  logic   accept;

  assign in_ready_o = (state_q == StIdle) && sts_i.slot_free;
  assign accept     = in_valid_i && in_ready_o;

  // plan for an incoming byte
  always_comb begin
    new_plan     = '0;
    new_plan.fin = in_last_i;
    case (sts_i.cls)
      ClsIdleAmp: begin
        new_plan.rp2 = in_last_i;
      end
      ClsIdleLit: begin
        new_plan.one = 1'b1;
      end
      ClsPush: begin
        new_plan.rp2 = in_last_i;
      end
      ClsClose: begin
        new_plan.one  = !sts_i.in_tag;
        new_plan.mark = 1'b1;
      end
      ClsBreak: begin
        new_plan.rp1 = 1'b1;
        new_plan.one = !sts_i.byte_amp;
        new_plan.rp2 = in_last_i && sts_i.byte_amp;
      end
      default: begin
        new_plan = '0;
      end
    endcase
    new_first = first_stage(new_plan);
    new_rest  = clear_one(new_plan);
    q_no_one  = clear_one(plan_q);
    q_no_rp   = clear_rp(plan_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    plan_d  = plan_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          case (new_first)
            StOne: begin
              plan_d  = new_rest;
              state_d = first_stage(new_rest);
            end
            StEnd: begin
              plan_d  = '0;
              state_d = StIdle;
            end
            default: begin
              plan_d  = new_plan;
              state_d = new_first;
            end
          endcase
        end
      end
      StRamp: begin
        if (sts_i.slot_free) begin
          if (sts_i.cnt_zero) begin
            plan_d  = q_no_rp;
            state_d = first_stage(q_no_rp);
          end else begin
            state_d = StRchr;
          end
        end
      end
      StRchr: begin
        if (sts_i.slot_free && sts_i.idx_end) begin
          plan_d  = q_no_rp;
          state_d = first_stage(q_no_rp);
        end
      end
      StOne: begin
        if (sts_i.slot_free) begin
          plan_d  = q_no_one;
          state_d = first_stage(q_no_one);
        end
      end
      StEnd: begin
        if (sts_i.slot_free) begin
          plan_d  = '0;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
        plan_d  = '0;
      end
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = accept;
    cmd_o.src      = SrcEnd;
    case (state_q)
      StIdle: begin
        if (accept && new_first == StOne) begin
          cmd_o.emit     = 1'b1;
          cmd_o.src      = new_plan.mark ? SrcMark : SrcLitIn;
          cmd_o.run_last = first_stage(new_rest) == StIdle;
        end else if (accept && new_first == StEnd) begin
          cmd_o.emit     = 1'b1;
          cmd_o.src      = SrcEnd;
          cmd_o.run_last = 1'b1;
        end
      end
      StRamp: begin
        cmd_o.emit     = 1'b1;
        cmd_o.src      = SrcAmp;
        cmd_o.rp_done  = sts_i.slot_free && sts_i.cnt_zero;
        cmd_o.run_last = sts_i.cnt_zero && (first_stage(q_no_rp) == StIdle);
      end
      StRchr: begin
        cmd_o.emit     = 1'b1;
        cmd_o.src      = SrcChr;
        cmd_o.idx_inc  = sts_i.slot_free && !sts_i.idx_end;
        cmd_o.rp_done  = sts_i.slot_free && sts_i.idx_end;
        cmd_o.run_last = sts_i.idx_end && (first_stage(q_no_rp) == StIdle);
      end
      StOne: begin
        cmd_o.emit     = 1'b1;
        cmd_o.src      = plan_q.mark ? SrcMark : SrcLitHold;
        cmd_o.run_last = first_stage(q_no_one) == StIdle;
      end
      StEnd: begin
        cmd_o.emit     = 1'b1;
        cmd_o.src      = SrcEnd;
        cmd_o.run_last = 1'b1;
      end
      default: begin
        cmd_o.emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      plan_q  <= '0;
    end else begin
      state_q <= state_d;
      plan_q  <= plan_d;
    end
  end

endmodule
